// ===== hw/rtl/atss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atss_pkg
// Shared types and codes for the array table with search and sort.
// ----------------------------------------------------------------------------
package atss_pkg;

  localparam int unsigned DepthDefault     = 256;
  localparam int unsigned DataWidthDefault = 32;
  localparam int unsigned PosW             = 8;
  localparam int unsigned ValW             = 32;
  localparam int unsigned CntW             = 9;
  localparam int unsigned ModeW            = 4;
  localparam int unsigned StatusW          = 3;

  typedef enum logic [ModeW-1:0] {
    MODE_APPEND  = 4'd0,
    MODE_INSERT  = 4'd1,
    MODE_POP     = 4'd2,
    MODE_CLEAR   = 4'd3,
    MODE_ERASE   = 4'd4,
    MODE_ERASE_R = 4'd5,
    MODE_READ    = 4'd6,
    MODE_WRITE   = 4'd7,
    MODE_LFIND   = 4'd8,
    MODE_SORT    = 4'd9,
    MODE_BFIND   = 4'd10
  } mode_t;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 3'd0,
    ST_FOUND = 3'd1,
    ST_MISS  = 3'd2,
    ST_FULL  = 3'd3,
    ST_BAD   = 3'd4
  } status_t;

endpackage : atss_pkg
`default_nettype wire

// ===== hw/rtl/array_table_with_search_and_sort.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// array_table_with_search_and_sort
// Packed array of signed words with a fill count, kept in one synchronous RAM.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. The result transaction follows when the
// work is done, and the next input waits until that result has been taken.
// Every memory access goes through the one synchronous RAM, which has a write
// port and a read port (one write and one read per cycle, read data registered).
// Append, pop, clear, write and the rejected cases answer as soon as the input
// is taken; read waits for its read data. Insert and erase move one entry at a
// time, a read and then a write. Linear find scans the entries in order and
// binary find halves the range on each compare. Sort is an insertion sort.
// A stalled receiver adds its stall to every item.
// No clearing pass is needed after reset.
module array_table_with_search_and_sort #(
  parameter int unsigned DEPTH      = atss_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = atss_pkg::DataWidthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [3:0] mode, [11:4] position, [19:12] position_end, [51:20] value
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] status, [10:3] found_index, [42:11] read_data, [51:43] fill_count
  output logic [55:0]      out_tdata
);
  import atss_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned IW = AW + 1;   // holds DEPTH itself
  localparam int unsigned DW = DATA_WIDTH;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SHUP  = 9'b000000010,   // insert: read i-1
    S_SHUPW = 9'b000000100,   // insert: write i
    S_SHDN  = 9'b000001000,   // erase: read i+n
    S_SHDNW = 9'b000010000,   // erase: write i
    S_LIN   = 9'b000100000,
    S_BIN   = 9'b001000000,
    S_SORT  = 9'b010000000,
    S_WAIT  = 9'b100000000    // waits for the registered read data, then finishes
  } state_t;

  typedef enum logic [2:0] {
    SO_LOADI = 3'b001,
    SO_CMP   = 3'b010,
    SO_MOVE  = 3'b100
  } sphase_t;

  state_t  state_r, state_nxt;
  sphase_t sph_r, sph_nxt;

  logic [DW-1:0] mem [DEPTH];
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  logic [IW-1:0]   cnt_r, cnt_nxt;
  logic [IW-1:0]   i_r, i_nxt, j_r, j_nxt, n_r, n_nxt, l_r, l_nxt, h_r, h_nxt;
  logic [IW-1:0]   pos_r, pos_nxt;
  logic [DW-1:0]   key_r, key_nxt, cur_r, cur_nxt;
  logic            rd_r, rd_nxt;       // lane checks the read data this cycle
  logic [IW-1:0]   ridx_r, ridx_nxt;   // index read last cycle
  logic            ovld_r, ovld_nxt;
  status_t         ost_r, ost_nxt;
  logic [PosW-1:0] oidx_r, oidx_nxt;
  logic [ValW-1:0] odat_r, odat_nxt;

  mode_t         in_mode;
  logic [IW-1:0] in_pos, in_pend;
  logic [DW-1:0] in_val;
  assign in_mode = mode_t'(in_tdata[3:0]);
  assign in_pos  = IW'(in_tdata[11:4]);
  assign in_pend = IW'(in_tdata[19:12]);
  assign in_val  = DW'($signed(in_tdata[51:20]));

  assign in_tready = (state_r == S_IDLE) && !ovld_r;
  assign out_tvalid = ovld_r;
  assign out_tdata = {4'd0, CntW'(cnt_r), odat_r, oidx_r, ost_r};

  logic take;
  assign take = in_tvalid && in_tready;

  logic [IW-1:0] mid;
  assign mid = IW'((l_r + h_r) >> 1);

  logic [DW-1:0] ka, kb;  // signed compare keys
  logic          done;

  always_comb begin
    state_nxt = state_r; sph_nxt = sph_r; cnt_nxt = cnt_r;
    i_nxt = i_r; j_nxt = j_r; n_nxt = n_r; l_nxt = l_r; h_nxt = h_r;
    pos_nxt = pos_r; key_nxt = key_r; cur_nxt = cur_r;
    rd_nxt = 1'b0; ridx_nxt = ridx_r;
    ovld_nxt = ovld_r; ost_nxt = ost_r; oidx_nxt = oidx_r; odat_nxt = odat_r;
    we = 1'b0; waddr = '0; wdata = key_r; raddr = '0;
    ka = '0; kb = '0; done = 1'b0;
    if (ovld_r && out_tready) ovld_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          ost_nxt = ST_DONE; oidx_nxt = '0; odat_nxt = '0;
          key_nxt = in_val; pos_nxt = in_pos;
          done = 1'b1;
          case (in_mode)
            MODE_APPEND: begin
              if (cnt_r >= IW'(DEPTH)) ost_nxt = ST_FULL;
              else begin
                we = 1'b1; waddr = AW'(cnt_r); wdata = in_val;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            MODE_INSERT: begin
              if (cnt_r >= IW'(DEPTH)) ost_nxt = ST_FULL;
              else if (in_pos > cnt_r) ost_nxt = ST_BAD;
              else begin
                i_nxt = cnt_r; state_nxt = S_SHUP; done = 1'b0;
              end
            end
            MODE_POP: begin
              if (cnt_r == '0) ost_nxt = ST_BAD;
              else cnt_nxt = cnt_r - 1'b1;
            end
            MODE_CLEAR: cnt_nxt = '0;
            MODE_ERASE, MODE_ERASE_R: begin
              if (in_mode == MODE_ERASE_R && in_pend < in_pos) begin
              end else if ((in_mode == MODE_ERASE ? in_pos : in_pend) >= cnt_r) begin
                ost_nxt = ST_BAD;
              end else begin
                n_nxt = (in_mode == MODE_ERASE) ? IW'(1) : IW'(in_pend - in_pos + 1'b1);
                i_nxt = in_pos; state_nxt = S_SHDN; done = 1'b0;
              end
            end
            MODE_READ, MODE_WRITE: begin
              if (in_pos >= cnt_r) ost_nxt = ST_BAD;
              else if (in_mode == MODE_WRITE) begin
                we = 1'b1; waddr = AW'(in_pos); wdata = in_val;
              end else begin
                raddr = AW'(in_pos); state_nxt = S_WAIT; done = 1'b0;
              end
            end
            MODE_LFIND: begin
              ost_nxt = ST_MISS;
              if (cnt_r != '0) begin
                raddr = '0; ridx_nxt = '0; rd_nxt = 1'b1; i_nxt = IW'(1);
                state_nxt = S_LIN; done = 1'b0;
              end
            end
            MODE_SORT: begin
              if (cnt_r > IW'(1)) begin
                i_nxt = IW'(1); sph_nxt = SO_LOADI; raddr = AW'(1);
                state_nxt = S_SORT; done = 1'b0;
              end
            end
            MODE_BFIND: begin
              ost_nxt = ST_MISS;
              if (cnt_r != '0) begin
                l_nxt = '0; h_nxt = cnt_r - 1'b1; rd_nxt = 1'b0;
                state_nxt = S_BIN; done = 1'b0;
              end
            end
            default: ;
          endcase
          if (done) ovld_nxt = 1'b1;
        end
      end
      S_SHUP: begin
        if (i_r == pos_r) begin
          we = 1'b1; waddr = AW'(pos_r); wdata = key_r;
          cnt_nxt = cnt_r + 1'b1; ovld_nxt = 1'b1; state_nxt = S_IDLE;
        end else begin
          raddr = AW'(i_r - 1'b1); state_nxt = S_SHUPW;
        end
      end
      S_SHUPW: begin
        we = 1'b1; waddr = AW'(i_r); wdata = rdata_r;
        i_nxt = i_r - 1'b1; state_nxt = S_SHUP;
      end
      S_SHDN: begin
        if (i_r + n_r >= cnt_r) begin
          cnt_nxt = cnt_r - n_r; ovld_nxt = 1'b1; state_nxt = S_IDLE;
        end else begin
          raddr = AW'(i_r + n_r); state_nxt = S_SHDNW;
        end
      end
      S_SHDNW: begin
        we = 1'b1; waddr = AW'(i_r); wdata = rdata_r;
        i_nxt = i_r + 1'b1; state_nxt = S_SHDN;
      end
      S_LIN: begin
        if (rd_r && rdata_r == key_r) begin
          ost_nxt = ST_FOUND; oidx_nxt = PosW'(ridx_r);
          ovld_nxt = 1'b1; state_nxt = S_IDLE;
        end else if (i_r >= cnt_r) begin
          ovld_nxt = 1'b1; state_nxt = S_IDLE;
        end else begin
          raddr = AW'(i_r); ridx_nxt = i_r; rd_nxt = 1'b1; i_nxt = i_r + 1'b1;
        end
      end
      S_BIN: begin
        // rd_r low: issue read of mid; high: decide on it
        if (!rd_r) begin
          raddr = AW'(mid); rd_nxt = 1'b1;
        end else begin
          ka = {~rdata_r[DW-1], rdata_r[DW-2:0]} ;
          kb = {~key_r[DW-1], key_r[DW-2:0]};
          if (rdata_r == key_r) begin
            ost_nxt = ST_FOUND; oidx_nxt = PosW'(mid);
            ovld_nxt = 1'b1; state_nxt = S_IDLE;
          end else if (ka < kb) begin
            if (mid + 1'b1 > h_r) begin ovld_nxt = 1'b1; state_nxt = S_IDLE; end
            else l_nxt = mid + 1'b1;
          end else begin
            if (mid == l_r) begin ovld_nxt = 1'b1; state_nxt = S_IDLE; end
            else h_nxt = mid - 1'b1;
          end
        end
      end
      S_SORT: begin
        case (sph_r)
          SO_LOADI: begin
            // element i is on the read port; start scan at j = i
            cur_nxt = rdata_r; j_nxt = i_r;
            raddr = AW'(i_r - 1'b1); sph_nxt = SO_CMP;
          end
          SO_CMP: begin
            ka = {~rdata_r[DW-1], rdata_r[DW-2:0]};
            kb = {~cur_r[DW-1], cur_r[DW-2:0]};
            if (ka > kb) begin
              we = 1'b1; waddr = AW'(j_r); wdata = rdata_r;
              j_nxt = j_r - 1'b1;
              if (j_r == IW'(1)) sph_nxt = SO_MOVE;
              else raddr = AW'(j_r - 2'd2);
            end else begin
              sph_nxt = SO_MOVE;
            end
          end
          SO_MOVE: begin
            we = 1'b1; waddr = AW'(j_r); wdata = cur_r;
            if (i_r + 1'b1 >= cnt_r) begin
              ovld_nxt = 1'b1; state_nxt = S_IDLE;
            end else begin
              i_nxt = i_r + 1'b1; raddr = AW'(i_r + 1'b1); sph_nxt = SO_LOADI;
            end
          end
          default: sph_nxt = SO_LOADI;
        endcase
      end
      S_WAIT: begin
        odat_nxt = ValW'($signed(rdata_r));
        ovld_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; sph_r <= SO_LOADI; cnt_r <= '0;
      ovld_r <= 1'b0; rd_r <= 1'b0;
    end else begin
      state_r <= state_nxt; sph_r <= sph_nxt; cnt_r <= cnt_nxt;
      ovld_r <= ovld_nxt; rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; j_r <= j_nxt; n_r <= n_nxt; l_r <= l_nxt; h_r <= h_nxt;
    pos_r <= pos_nxt; key_r <= key_nxt; cur_r <= cur_nxt; ridx_r <= ridx_nxt;
    ost_r <= ost_nxt; oidx_r <= oidx_nxt; odat_r <= odat_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= IW'(DEPTH)) else $error("fill count beyond depth");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
    we && state_r != S_IDLE |-> {1'b0, waddr} <= cnt_r) else $error("write past fill");

endmodule : array_table_with_search_and_sort
`default_nettype wire

// ===== test/array_table_with_search_and_sort_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_table_with_search_and_sort_tb
// Drives mixed table operations into the array table and compares every
// result transaction against a behavioural copy of the table kept here.
// ----------------------------------------------------------------------------
module array_table_with_search_and_sort_tb;
  import atss_pkg::*;

  localparam int Depth = 256;

  // first member is the most significant: status sits in the lowest bits
  typedef struct packed {
    logic [8:0]  fill_count;
    logic [31:0] read_data;
    logic [7:0]  found_index;
    logic [2:0]  status;
  } table_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;

  array_table_with_search_and_sort dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  logic signed [31:0] shadow_store [Depth];
  int unsigned        shadow_count;
  table_result_t      pending_results [$];
  int                 error_count;
  int                 hold_off_cycles;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compute the result of one operation and update the shadow table.
  function automatic table_result_t apply_table_op(logic [3:0] mode, logic [7:0] pos,
                                                   logic [7:0] pend, logic signed [31:0] val);
    table_result_t r;
    int i, j, l, h, mid, n;
    logic signed [31:0] cur;
    r = '0;
    r.status = ST_DONE;
    case (mode)
      MODE_APPEND: begin
        if (shadow_count >= Depth) r.status = ST_FULL;
        else begin
          shadow_store[shadow_count] = val;
          shadow_count++;
        end
      end
      MODE_INSERT: begin
        if (shadow_count >= Depth) r.status = ST_FULL;
        else if (pos > shadow_count) r.status = ST_BAD;
        else begin
          for (i = shadow_count; i > pos; i--) shadow_store[i] = shadow_store[i-1];
          shadow_store[pos] = val;
          shadow_count++;
        end
      end
      MODE_POP: begin
        if (shadow_count == 0) r.status = ST_BAD;
        else shadow_count--;
      end
      MODE_CLEAR: shadow_count = 0;
      MODE_ERASE, MODE_ERASE_R: begin
        if (mode == MODE_ERASE && pos >= shadow_count) r.status = ST_BAD;
        else if (mode == MODE_ERASE_R && pend < pos) r.status = ST_DONE;
        else if (mode == MODE_ERASE_R && pend >= shadow_count) r.status = ST_BAD;
        else begin
          n = (mode == MODE_ERASE) ? 1 : pend - pos + 1;
          for (i = pos; i + n < shadow_count; i++) shadow_store[i] = shadow_store[i+n];
          shadow_count -= n;
        end
      end
      MODE_READ: begin
        if (pos >= shadow_count) r.status = ST_BAD;
        else r.read_data = shadow_store[pos];
      end
      MODE_WRITE: begin
        if (pos >= shadow_count) r.status = ST_BAD;
        else shadow_store[pos] = val;
      end
      MODE_LFIND: begin
        r.status = ST_MISS;
        for (i = 0; i < shadow_count; i++)
          if (shadow_store[i] == val) begin
            r.status = ST_FOUND;
            r.found_index = 8'(i);
            break;
          end
      end
      MODE_SORT: begin
        for (i = 1; i < shadow_count; i++) begin
          cur = shadow_store[i];
          j = i;
          while (j > 0 && shadow_store[j-1] > cur) begin
            shadow_store[j] = shadow_store[j-1];
            j--;
          end
          shadow_store[j] = cur;
        end
      end
      MODE_BFIND: begin
        r.status = ST_MISS;
        l = 0;
        h = int'(shadow_count) - 1;
        while (l <= h) begin
          mid = (l + h) / 2;
          if (shadow_store[mid] == val) begin
            r.status = ST_FOUND;
            r.found_index = 8'(mid);
            break;
          end else if (shadow_store[mid] < val) l = mid + 1;
          else h = mid - 1;
        end
      end
      default: ;
    endcase
    r.fill_count = 9'(shadow_count);
    return r;
  endfunction

  task automatic send_op(logic [3:0] mode, logic [7:0] pos, logic [7:0] pend,
                         logic [31:0] val);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pending_results.push_back(apply_table_op(mode, pos, pend, val));
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, val, pend, pos, mode};
    do @(posedge clk); while (!in_tready);
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    table_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[51:0];
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); error_count++;
        end
        if (got.found_index !== want.found_index) begin
          $error("found_index exp %0d got %0d", want.found_index, got.found_index);
          error_count++;
        end
        if (got.read_data !== want.read_data) begin
          $error("read_data exp %h got %h", want.read_data, got.read_data);
          error_count++;
        end
        if (got.fill_count !== want.fill_count) begin
          $error("fill_count exp %0d got %0d", want.fill_count, got.fill_count);
          error_count++;
        end
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return $urandom_range(0, 15) - 8;
    endcase
  endfunction

  task automatic test_directed();
    send_op(MODE_POP, 0, 0, 0);
    send_op(MODE_LFIND, 0, 0, 5);
    send_op(MODE_BFIND, 0, 0, 5);
    send_op(MODE_READ, 0, 0, 0);
    send_op(MODE_INSERT, 1, 0, 1);
    send_op(MODE_APPEND, 0, 0, 32'h7fff_ffff);
    send_op(MODE_APPEND, 0, 0, 32'h8000_0000);
    send_op(MODE_INSERT, 2, 0, 3);
    send_op(MODE_INSERT, 0, 0, 3);
    send_op(MODE_LFIND, 0, 0, 3);
    send_op(MODE_BFIND, 0, 0, 32'h8000_0000);
    send_op(MODE_WRITE, 1, 0, 32'hffff_ffff);
    send_op(MODE_WRITE, 255, 0, 1);
    send_op(MODE_READ, 1, 0, 0);
    send_op(MODE_SORT, 0, 0, 0);
    send_op(MODE_BFIND, 0, 0, 3);
    send_op(MODE_ERASE_R, 2, 1, 0);
    send_op(MODE_ERASE_R, 1, 255, 0);
    send_op(MODE_ERASE_R, 1, 2, 0);
    send_op(MODE_ERASE, 3, 0, 0);
    send_op(MODE_ERASE, 0, 0, 0);
    send_op(4'd11, 8'hff, 8'hff, 32'hffff_ffff);
    send_op(4'd15, 0, 0, 0);
    send_op(MODE_CLEAR, 0, 0, 0);
  endtask

  // Fill to capacity, hit the full store, then erase the whole table as a range; receiver holds off.
  task automatic test_full_store();
    int i;
    hold_off_cycles = 300;
    for (i = 0; i < Depth; i++) send_op(MODE_APPEND, 0, 0, pick_value());
    send_op(MODE_APPEND, 0, 0, 1);
    send_op(MODE_INSERT, 8'hff, 0, 1);
    send_op(MODE_READ, 8'hff, 0, 0);
    send_op(MODE_LFIND, 0, 0, shadow_store[255]);
    send_op(MODE_ERASE_R, 0, 8'hff, 0);
  endtask

  task automatic test_random(int n);
    int i, k;
    logic [3:0]  mode;
    logic [7:0]  pos;
    for (i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 25) mode = MODE_APPEND;
      else if (k < 35) mode = MODE_INSERT;
      else if (k < 40) mode = MODE_POP;
      else if (k < 41) mode = MODE_CLEAR;
      else if (k < 47) mode = MODE_ERASE;
      else if (k < 50) mode = MODE_ERASE_R;
      else if (k < 60) mode = MODE_READ;
      else if (k < 67) mode = MODE_WRITE;
      else if (k < 77) mode = MODE_LFIND;
      else if (k < 82) mode = MODE_SORT;
      else if (k < 96) mode = MODE_BFIND;
      else mode = 4'($urandom_range(0, 15));
      // keep the table small so sorts stay short
      if (shadow_count > 40 && mode == MODE_APPEND) mode = MODE_POP;
      if ($urandom_range(0, 7) == 0) pos = 8'($urandom);
      else pos = 8'($urandom_range(0, shadow_count));
      send_op(mode, pos,
              ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(pos + $urandom_range(0, 3)),
              (mode >= MODE_LFIND && shadow_count > 0 && $urandom_range(0, 1))
                ? shadow_store[$urandom_range(0, shadow_count - 1)] : pick_value());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    error_count = 0;
    hold_off_cycles = 0;
    shadow_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_random(1250);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
